// ===== design/shp3x3_pkg.sv =====
// ----------------------------------------------------------------------------
// Sharpen 3x3 cross kernel package
// Shared widths, register indexes, reset values and constants of the
// sharpening filter.
// ----------------------------------------------------------------------------
package shp3x3_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam int SAMPLE_W    = 8;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 8;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_CHAN_W   = 3;

  localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 16'd480;
  localparam logic [CFG_CHAN_W-1:0]   RST_CHANNEL_COUNT = 3'd1;

  localparam int SHARPEN_GAIN = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

endpackage

// ===== design/sharpen_3x3_cross_kernel_top.sv =====
// ----------------------------------------------------------------------------
// Sharpen 3x3 cross kernel top level
// An input transfer is registered with its store reads in stage one, then its
// result in the output register. One sample per cycle while the single output
// port accepts; last-row samples give two results each and hold the input.
// Reset clears position counters, bank select, pipeline valids and config;
// the line stores are not cleared.
// ----------------------------------------------------------------------------
module sharpen_3x3_cross_kernel_top
  import shp3x3_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] sample
  input  logic [0:0]            s_axis_tuser,  // [0] start_of_frame
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [7:0] value
  output logic                  m_axis_tlast,
  output logic [0:0]            m_axis_tuser   // [0] end_of_frame
);

  localparam int Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = AW + 2;
  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EwW   = $clog2(MAX_WIDTH + 1);
  localparam int EcW   = $clog2(MAX_CHANNELS + 1);
  localparam int AccW  = 12;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                has_a;
    logic                interior;
    logic                last_row;
    logic                eof;
    logic                older_bank;
  } s1_t;

  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  logic [CFG_CHAN_W-1:0]   chan_q;

  logic [EwW-1:0]          eff_w;
  logic [CFG_HEIGHT_W-1:0] eff_h;
  logic [EcW-1:0]          eff_c;

  logic [CFG_HEIGHT_W-1:0] row_q, row_d, cur_row;
  logic [ColW-1:0]         col_q, col_d, cur_col;
  logic [ChW-1:0]          ch_q, ch_d, cur_ch;
  logic                    bank_q, bank_d;

  logic          in_xfer, out_xfer, out_free, s1_adv;
  logic          col_last, ch_last, border;
  logic [PW-1:0] p_full;
  logic [AW-1:0] addr [3];
  logic [SAMPLE_W-1:0] rd [2][3];

  logic s1_valid_q;
  s1_t  s1_q, s1_d;

  logic                 oa_valid_q, ob_valid_q;
  logic [SAMPLE_W-1:0]  oa_value_q;
  logic                 oa_last_q, ob_eof_q;

  logic [SAMPLE_W-1:0]    po, pl, pc, pr;
  logic signed [AccW-1:0] acc;
  logic [SAMPLE_W-1:0]    a_value;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      chan_q   <= RST_CHANNEL_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i[CFG_HEIGHT_W-1:0];
        CFG_CHANNEL_COUNT: chan_q   <= cfg_wdata_i[CFG_CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < 11'd3) begin
      eff_w = EwW'(3);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = EwW'(MAX_WIDTH);
    end else begin
      eff_w = EwW'(width_q);
    end
    eff_h = (height_q < 16'd3) ? 16'd3 : height_q;
    if (chan_q == 3'd0) begin
      eff_c = EcW'(1);
    end else if (32'(chan_q) > 32'(MAX_CHANNELS)) begin
      eff_c = EcW'(MAX_CHANNELS);
    end else begin
      eff_c = EcW'(chan_q);
    end
  end

  // Position of the incoming sample and its store addresses.
  always_comb begin
    cur_row  = s_axis_tuser[0] ? '0 : row_q;
    cur_col  = s_axis_tuser[0] ? '0 : col_q;
    cur_ch   = s_axis_tuser[0] ? '0 : ch_q;
    p_full   = PW'(cur_col) * PW'(eff_c) + PW'(cur_ch);
    addr[0]  = AW'(p_full - PW'(eff_c));
    addr[1]  = AW'(p_full);
    addr[2]  = AW'(p_full + PW'(eff_c));
    col_last = 32'(cur_col) >= 32'(eff_w) - 32'd1;
    ch_last  = 32'(cur_ch) >= 32'(eff_c) - 32'd1;
    border   = (cur_col == '0) || col_last;

    s1_d.sample     = s_axis_tdata[SAMPLE_W-1:0];
    s1_d.has_a      = cur_row != '0;
    s1_d.interior   = !border && (cur_row >= 16'd2) && (cur_row < eff_h);
    s1_d.last_row   = 32'(cur_row) >= 32'(eff_h) - 32'd1;
    s1_d.eof        = col_last && ch_last;
    s1_d.older_bank = bank_q;

    row_d  = cur_row;
    col_d  = cur_col;
    ch_d   = cur_ch;
    bank_d = bank_q;
    if (32'(cur_ch) + 32'd1 >= 32'(eff_c)) begin
      ch_d = '0;
      if (32'(cur_col) + 32'd1 >= 32'(eff_w)) begin
        col_d  = '0;
        bank_d = !bank_q;
        row_d  = (32'(cur_row) + 32'd1 >= 32'(eff_h)) ? '0 : cur_row + 16'd1;
      end else begin
        col_d = cur_col + ColW'(1);
      end
    end else begin
      ch_d = cur_ch + ChW'(1);
    end
  end

  // Two line-store banks, each kept in three copies so that the left,
  // center and right taps of the prior row can be read in the same cycle.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    for (genvar k = 0; k < 3; k++) begin : g_copy
      shp3x3_ram #(
        .Width (SAMPLE_W),
        .Depth (Depth)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (in_xfer && (bank_q == 1'(b))),
        .waddr_i (addr[1]),
        .wdata_i (s_axis_tdata[SAMPLE_W-1:0]),
        .re_i    (in_xfer),
        .raddr_i (addr[k]),
        .rdata_o (rd[b][k])
      );
    end
  end

  // Handshake and pipeline control.
  assign m_axis_tvalid = oa_valid_q || ob_valid_q;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign out_free      = !m_axis_tvalid || (out_xfer && !(oa_valid_q && ob_valid_q));
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      ch_q   <= '0;
      bank_q <= 1'b0;
    end else if (in_xfer) begin
      row_q  <= row_d;
      col_q  <= col_d;
      ch_q   <= ch_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  // Cross-kernel arithmetic on the registered store reads.
  always_comb begin
    po  = rd[s1_q.older_bank][1];
    pl  = rd[!s1_q.older_bank][0];
    pc  = rd[!s1_q.older_bank][1];
    pr  = rd[!s1_q.older_bank][2];
    acc = AccW'(SHARPEN_GAIN) * $signed({4'b0, pc})
        - $signed({4'b0, pl}) - $signed({4'b0, pr})
        - $signed({4'b0, po}) - $signed({4'b0, s1_q.sample});
    if (!s1_q.interior || acc < 0) begin
      a_value = '0;
    end else if (acc > 12'sd255) begin
      a_value = '1;
    end else begin
      a_value = acc[SAMPLE_W-1:0];
    end
  end

  // Output register: up to two results per sample, delivered in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oa_valid_q <= 1'b0;
      ob_valid_q <= 1'b0;
    end else if (s1_adv) begin
      oa_valid_q <= s1_q.has_a;
      ob_valid_q <= s1_q.last_row;
    end else if (out_xfer) begin
      if (oa_valid_q) begin
        oa_valid_q <= 1'b0;
      end else begin
        ob_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      oa_value_q <= a_value;
      oa_last_q  <= !s1_q.last_row;
      ob_eof_q   <= s1_q.eof;
    end
  end

  assign m_axis_tdata    = oa_valid_q ? M_TDATA_W'(oa_value_q) : '0;
  assign m_axis_tlast    = oa_valid_q ? oa_last_q : 1'b1;
  assign m_axis_tuser[0] = oa_valid_q ? 1'b0 : ob_eof_q;

endmodule

// ===== design/shp3x3_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read output. A read
// and a write to the same address in the same cycle return the old contents.
// ----------------------------------------------------------------------------
module shp3x3_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/shp3x3_checker.sv =====
// ----------------------------------------------------------------------------
// Sharpen 3x3 cross kernel port checker
// Concurrent checks on the output stream of the top level, attached by bind.
// ----------------------------------------------------------------------------
module shp3x3_checker
  import shp3x3_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic [0:0]           m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("Output transfer changed while stalled.");

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("End of frame on a result that does not close its run.");

  a_eof_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("End of frame result carries a nonzero border value.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("Output valid after a cycle in reset.");

endmodule

bind sharpen_3x3_cross_kernel_top shp3x3_checker u_checker (.*);
